@@ rtl/fdc_pkg.sv @@
// Package for the frame deframer and checker: channel item types, phase codes,
// status codes and register map constants.
// No dependencies; every other file in rtl but fdc_chan_if refers to it by scoped names.
`default_nettype none

package fdc_pkg;

  // Frame delimiters.
  localparam logic [7:0] HEAD_BYTE = 8'hAA;
  localparam logic [7:0] TAIL_BYTE = 8'h55;

  // Report status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_INCOMPLETE = 2'd1;
  localparam logic [1:0] ST_BAD        = 2'd2;
  localparam logic [1:0] ST_TOO_LONG   = 2'd3;

  // Result kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_REPORT  = 1'b1;

  // Configuration register map: one 32-bit register, word-addressed by paddr[2].
  localparam int unsigned ADDR_W = 3;
  localparam logic REG_MAX_PAYLOAD_LEN = 1'b0;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN_LO  = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK   = 3'd4,
    PH_TAIL    = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  out_byte;
    logic [1:0]  status;
    logic [15:0] skipped_bytes;
    logic [15:0] frame_payload_len;
    logic        last;
  } out_item_t;

  // Up to two results produced by one input byte, written into the result queue.
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } push_t;

endpackage

`default_nettype wire

@@ rtl/fdc_chan_if.sv @@
// Valid/ready channel interface carrying one payload item per transfer.
// The payload type is given by the instantiating module, normally from fdc_pkg.
`default_nettype none

interface fdc_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

@@ rtl/fdc_regs.sv @@
// APB-style configuration register block holding the maximum payload length.
// Depends on fdc_pkg for the address width and register map.
`default_nettype none

module fdc_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [fdc_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  output logic      [15:0]                  max_payload_len
);

  logic wr_en;
  logic hit;

  // Byte address bits are ignored; paddr[2] selects the word.
  assign hit    = (paddr[2] == fdc_pkg::REG_MAX_PAYLOAD_LEN);
  assign wr_en  = psel && penable && pwrite && hit;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_len <= 16'hFFFF;
    end else if (wr_en) begin
      max_payload_len <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (hit) begin
      prdata = {16'd0, max_payload_len};
    end
  end

endmodule

`default_nettype wire

@@ rtl/fdc_core.sv @@
// Deframer core: input register, frame state and the per-byte update that
// produces up to two results. Depends on fdc_pkg and fdc_chan_if.
`default_nettype none

module fdc_core (
  input  wire logic           clk,
  input  wire logic           rst,
  fdc_chan_if.sink            bytes,
  input  wire logic [15:0]    max_payload_len,
  input  wire logic           room,
  output fdc_pkg::push_t      push
);

  // Input register.
  logic              in_valid;
  fdc_pkg::in_item_t in_item;
  logic              fire;

  // Frame state.
  fdc_pkg::phase_t phase, phase_next;
  logic [15:0] length_reg, length_reg_next;
  logic [15:0] byte_count, byte_count_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [15:0] skip_count, skip_count_next;
  logic        checksum_ok, checksum_ok_next;

  // Working signals for the update.
  logic [7:0]  b;
  logic        eob;
  logic [7:0]  sum_add;
  logic [15:0] len_full;
  logic [15:0] count_inc;
  logic        rep;
  logic [1:0]  rep_status;
  logic        rep_last;
  logic        frame_active;
  fdc_pkg::out_item_t rep_item;
  fdc_pkg::out_item_t pay_item;
  logic        pay;

  assign fire        = in_valid && room;
  assign bytes.ready = !in_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (bytes.ready) begin
      in_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.ready && bytes.valid) begin
      in_item <= bytes.data;
    end
  end

  assign b         = in_item.in_byte;
  assign eob       = in_item.end_of_buffer;
  assign sum_add   = running_sum + b;
  assign len_full  = length_reg | {b, 8'd0};
  assign count_inc = byte_count + 16'd1;

  always_comb begin
    phase_next       = phase;
    length_reg_next  = length_reg;
    byte_count_next  = byte_count;
    running_sum_next = running_sum;
    skip_count_next  = skip_count;
    checksum_ok_next = checksum_ok;
    rep              = 1'b0;
    rep_status       = fdc_pkg::ST_INCOMPLETE;
    rep_last         = 1'b1;
    pay              = 1'b0;

    unique case (phase)
      fdc_pkg::PH_LEN_LO: begin
        length_reg_next  = {8'd0, b};
        running_sum_next = sum_add;
        phase_next       = fdc_pkg::PH_LEN_HI;
      end
      fdc_pkg::PH_LEN_HI: begin
        length_reg_next  = len_full;
        running_sum_next = sum_add;
        byte_count_next  = 16'd0;
        phase_next       = (len_full == 16'd0) ? fdc_pkg::PH_CHECK : fdc_pkg::PH_PAYLOAD;
        if (len_full > max_payload_len) begin
          rep        = 1'b1;
          rep_status = fdc_pkg::ST_TOO_LONG;
          rep_last   = eob;
        end
      end
      fdc_pkg::PH_PAYLOAD: begin
        running_sum_next = sum_add;
        pay              = 1'b1;
        byte_count_next  = count_inc;
        if (count_inc >= length_reg) begin
          phase_next = fdc_pkg::PH_CHECK;
        end
      end
      fdc_pkg::PH_CHECK: begin
        checksum_ok_next = (b == running_sum);
        phase_next       = fdc_pkg::PH_TAIL;
      end
      fdc_pkg::PH_TAIL: begin
        rep        = 1'b1;
        rep_status = (b == fdc_pkg::TAIL_BYTE && checksum_ok) ?
                     fdc_pkg::ST_OK : fdc_pkg::ST_BAD;
        rep_last   = eob;
      end
      default: begin
        // Hunting; unused phase codes behave the same way.
        if (b == fdc_pkg::HEAD_BYTE) begin
          length_reg_next  = 16'd0;
          byte_count_next  = 16'd0;
          running_sum_next = 8'd0;
          checksum_ok_next = 1'b0;
          phase_next       = fdc_pkg::PH_LEN_LO;
        end else begin
          phase_next = fdc_pkg::PH_HUNT;
          if (skip_count != 16'hFFFF) begin
            skip_count_next = skip_count + 16'd1;
          end
        end
      end
    endcase

    // The end of the buffer closes any frame that has not already reported.
    if (!rep && eob) begin
      rep = 1'b1;
    end

    frame_active = (phase_next == fdc_pkg::PH_PAYLOAD) ||
                   (phase_next == fdc_pkg::PH_CHECK) ||
                   (phase_next == fdc_pkg::PH_TAIL);

    rep_item.kind              = fdc_pkg::KIND_REPORT;
    rep_item.out_byte          = 8'd0;
    rep_item.status            = rep_status;
    rep_item.skipped_bytes     = skip_count_next;
    rep_item.frame_payload_len = frame_active ? length_reg_next : 16'd0;
    rep_item.last              = rep_last;

    pay_item                   = '0;
    pay_item.kind              = fdc_pkg::KIND_PAYLOAD;
    pay_item.out_byte          = b;

    if (rep) begin
      phase_next       = fdc_pkg::PH_HUNT;
      length_reg_next  = 16'd0;
      byte_count_next  = 16'd0;
      running_sum_next = 8'd0;
      skip_count_next  = 16'd0;
      checksum_ok_next = 1'b0;
    end

    push = '0;
    if (fire) begin
      if (pay) begin
        push.first  = pay_item;
        push.second = rep_item;
        push.count  = rep ? 2'd2 : 2'd1;
      end else begin
        push.first  = rep_item;
        push.count  = rep ? 2'd1 : 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= fdc_pkg::PH_HUNT;
      length_reg  <= 16'd0;
      byte_count  <= 16'd0;
      running_sum <= 8'd0;
      skip_count  <= 16'd0;
      checksum_ok <= 1'b0;
    end else if (fire) begin
      phase       <= phase_next;
      length_reg  <= length_reg_next;
      byte_count  <= byte_count_next;
      running_sum <= running_sum_next;
      skip_count  <= skip_count_next;
      checksum_ok <= checksum_ok_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/fdc_out_fifo.sv @@
// Result queue: takes up to two results per cycle and hands out one per
// transfer. Depends on fdc_pkg and fdc_chan_if.
`default_nettype none

module fdc_out_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire fdc_pkg::push_t push,
  output logic                room,
  fdc_chan_if.source          results
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  fdc_pkg::out_item_t mem [DEPTH];
  logic [IW-1:0] wptr, wptr_next, wptr_inc1, wptr_inc2;
  logic [IW-1:0] rptr, rptr_next;
  logic [CW-1:0] count, count_next;
  logic          pop;

  assign wptr_inc1 = (wptr == IW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
  assign wptr_inc2 = (wptr_inc1 == IW'(DEPTH - 1)) ? '0 : wptr_inc1 + 1'b1;

  assign pop           = results.valid && results.ready;
  assign results.valid = (count != '0);
  assign results.data  = mem[rptr];

  // Room for the worst case of two results from the next byte.
  assign room = (count <= CW'(DEPTH - 2));

  always_comb begin
    case (push.count)
      2'd1:    wptr_next = wptr_inc1;
      2'd2:    wptr_next = wptr_inc2;
      default: wptr_next = wptr;
    endcase
    rptr_next = rptr;
    if (pop) begin
      rptr_next = (rptr == IW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
    end
    count_next = count + CW'(push.count) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wptr_inc1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr_next;
      rptr  <= rptr_next;
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/frame_deframer_checker_unit.sv @@
// Top level of the length-prefixed frame deframer with additive checksum.
// Depends on fdc_pkg, fdc_chan_if, fdc_regs, fdc_core and fdc_out_fifo.
//
//   Channel   Direction  Carries
//   bytes     in         in_byte, end_of_buffer: one received byte per transfer
//   results   out        kind, out_byte, status, skipped_bytes,
//                        frame_payload_len, last: one result per transfer
//   APB       in/out     max_payload_len at byte address 0
//
// One byte is taken per cycle while the result queue has room for two more
// results. A byte captured in the input register is processed from there and
// its results are written into the result queue, which drives the result port.
// A byte that forwards a payload byte and also ends the buffer gives two
// results, which the result queue delivers in two transfers; this queue's
// depth sets how long the input keeps flowing while the output is stalled.
// The byte port stalls only when the queue cannot take two more results.
// Reset (rst, synchronous) returns the deframer to hunting for the head byte,
// empties the result queue and sets the maximum payload length to 65535.
`default_nettype none

module frame_deframer_checker_unit #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  fdc_chan_if.sink                         bytes,
  fdc_chan_if.source                       results,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [fdc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);

  logic [15:0]    max_payload_len;
  logic           room;
  fdc_pkg::push_t push;

  // The register block holds the length limit; the user must write it only while the
  // deframer is idle (the block does not enforce this), so the core reads it directly.
  fdc_regs u_regs (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .max_payload_len (max_payload_len)
  );

  // The core registers each byte, advances the frame phase and produces a
  // forwarded payload byte, a frame report, both or neither.
  fdc_core u_core (
    .clk             (clk),
    .rst             (rst),
    .bytes           (bytes),
    .max_payload_len (max_payload_len),
    .room            (room),
    .push            (push)
  );

  // The result queue separates the core from the consumer, so that the next
  // byte is processed while earlier results still wait for their transfer.
  fdc_out_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_out_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .room    (room),
    .results (results)
  );

endmodule

`default_nettype wire
